// ===== rtl/core/pidaw_pkg.sv =====
// pidaw_pkg: shared constants for the pid controller with anti-windup
// command codes, register indexes and default sizes; no dependencies
package pidaw_pkg;

   localparam int DEF_DATA_WIDTH  = 32;
   localparam int DEF_FRAC_BITS   = 16;
   localparam int LIMIT_WIDTH     = 31;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [1:0] CMD_UPDATE = 2'd0;
   localparam logic [1:0] CMD_RESET  = 2'd1;
   localparam logic [1:0] CMD_BACK   = 2'd2;
   localparam logic [1:0] CMD_ADD    = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PROP_GAIN    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INTEG_GAIN   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DERIV_GAIN   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SP_WEIGHT    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DERIV_FILTER = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TRACK_TIME   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INTEG_LIMIT  = 3'd6;

endpackage

// ===== rtl/core/pid_controller_antiwindup_core.sv =====
// pid_controller_antiwindup_core: fixed-point pid controller, one shared
// multiplier and one radix-2 divider under a one-hot sequencer; uses pidaw_pkg
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/stall    | command, setpoint, measured, ...
//   rsp_    | out       | rsp_valid/stall    | drive, raw_drive, saturated, integ
//   csr_    | in        | csr_valid/ready    | index, data
//
// one word at a time; req_stall is high from acceptance until the result is taken
// update: up to three divisions, each through the shared serial divider
// back-calculate: one division and one multiply; reset and add use neither
// the serial divider, one quotient bit a cycle, sets the item time
// synchronous active-high reset clears state and registers to defaults
module pid_controller_antiwindup_core #(
   parameter int DATA_WIDTH = pidaw_pkg::DEF_DATA_WIDTH,
   parameter int FRAC_BITS  = pidaw_pkg::DEF_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_command,
   input  logic signed [DATA_WIDTH-1:0]          req_setpoint,
   input  logic signed [DATA_WIDTH-1:0]          req_measured,
   input  logic signed [DATA_WIDTH-1:0]          req_step_time,
   input  logic signed [DATA_WIDTH-1:0]          req_feedforward,
   input  logic signed [DATA_WIDTH-1:0]          req_drive_min,
   input  logic signed [DATA_WIDTH-1:0]          req_drive_max,
   input  logic signed [DATA_WIDTH-1:0]          req_amount,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [DATA_WIDTH-1:0]          rsp_drive,
   output logic signed [DATA_WIDTH-1:0]          rsp_raw_drive,
   output logic                                  rsp_saturated,
   output logic signed [DATA_WIDTH-1:0]          rsp_integrator_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pidaw_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]                 csr_data
);
   import pidaw_pkg::*;

   localparam int W    = DATA_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int NW   = W + F;
   localparam int CNTW = $clog2(NW + 1);
   localparam int CW   = (W >= LIMIT_WIDTH) ? W + 1 : LIMIT_WIDTH + 1;
   localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [CNTW-1:0] DIV_STEPS = CNTW'(NW);

   typedef enum logic [21:0] {
      ST_IDLE     = 22'd1 << 0,
      ST_DISPATCH = 22'd1 << 1,
      ST_U_PE     = 22'd1 << 2,
      ST_U_P      = 22'd1 << 3,
      ST_U_DY     = 22'd1 << 4,
      ST_U_AL     = 22'd1 << 5,
      ST_U_FL     = 22'd1 << 6,
      ST_U_D      = 22'd1 << 7,
      ST_U_DN     = 22'd1 << 8,
      ST_U_RAW    = 22'd1 << 9,
      ST_U_CLP    = 22'd1 << 10,
      ST_U_TC     = 22'd1 << 11,
      ST_U_RT     = 22'd1 << 12,
      ST_U_KE     = 22'd1 << 13,
      ST_C2_Q     = 22'd1 << 14,
      ST_U_IA     = 22'd1 << 15,
      ST_I_CLAMP  = 22'd1 << 16,
      ST_MUL      = 22'd1 << 17,
      ST_DIV      = 22'd1 << 18,
      ST_DIVFIN   = 22'd1 << 19,
      ST_OUT      = 22'd1 << 20,
      ST_SPARE    = 22'd1 << 21
   } state_type;

   function automatic logic signed [W+1:0] ext(input logic signed [W-1:0] a);
      return (W+2)'(a);
   endfunction

   function automatic logic signed [W-1:0] sat_s(input logic signed [W+1:0] v);
      if (v > (W+2)'(VMAX)) return VMAX;
      else if (v < (W+2)'(VMIN)) return VMIN;
      else return v[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sat_p(input logic signed [2*W-1:0] v);
      logic signed [2*W-1:0] sh;
      sh = v >>> F;
      if (sh > (2*W)'(VMAX)) return VMAX;
      else if (sh < (2*W)'(VMIN)) return VMIN;
      else return sh[W-1:0];
   endfunction

   state_type state_ff, state_in, ret_ff, ret_in, ret_sel;
   logic [1:0] cmd_ff, cmd_in;
   logic signed [W-1:0] setpoint_ff, setpoint_in, measured_ff, measured_in;
   logic signed [W-1:0] step_time_ff, step_time_in, feedforward_ff, feedforward_in;
   logic signed [W-1:0] drive_min_ff, drive_min_in, drive_max_ff, drive_max_in;
   logic signed [W-1:0] amount_ff, amount_in, err_ff, err_in, prop_ff, prop_in;
   logic signed [W-1:0] dy_ff, dy_in, corr_ff, corr_in, deriv_ff, deriv_in;
   logic signed [W-1:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic signed [2*W-1:0] prod_ff, prod_in;
   logic [NW-1:0] dq_ff, dq_in;
   logic [W-1:0] drem_ff, drem_in, dden_ff, dden_in;
   logic dneg_ff, dneg_in, dzero_ff, dzero_in, danum_ff, danum_in;
   logic [CNTW-1:0] dcnt_ff, dcnt_in;
   logic signed [W-1:0] divq_ff, divq_in;
   logic signed [W-1:0] drive_ff, drive_in, raw_ff, raw_in;
   logic satd_ff, satd_in;
   logic signed [W-1:0] integ_ff, integ_in, filt_ff, filt_in, prev_ff, prev_in;
   logic have_prev_ff, have_prev_in;

   logic signed [W-1:0] kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in, sw_ff, sw_in;
   logic signed [W-1:0] tf_ff, tf_in, tt_ff, tt_in;
   logic [LIMIT_WIDTH-1:0] limit_ff, limit_in;

   logic mul_go, div_go;
   logic signed [W-1:0] mul_a_sel, mul_b_sel, div_a_sel, div_b_sel;
   logic [W-1:0] abs_a, abs_b;
   logic signed [W-1:0] mulq, tf_pos, hi_eff, drive_c;
   logic satd_c, pushing, dt_pos, tt_pos, err_pos;
   logic [W:0] rem_sh, rem_sub;
   logic rem_ge, q_big;
   logic signed [CW-1:0] integ_x, lim_x, nlim_x;

   assign mulq    = sat_p(prod_ff);
   assign dt_pos  = !step_time_ff[W-1] && (step_time_ff != '0);
   assign tt_pos  = !tt_ff[W-1] && (tt_ff != '0);
   assign err_pos = !err_ff[W-1] && (err_ff != '0);
   assign tf_pos  = tf_ff[W-1] ? '0 : tf_ff;
   assign hi_eff  = (drive_max_ff < drive_min_ff) ? drive_min_ff : drive_max_ff;
   assign drive_c = (raw_ff < drive_min_ff) ? drive_min_ff :
                    ((raw_ff > hi_eff) ? hi_eff : raw_ff);
   assign satd_c  = drive_c != raw_ff;
   assign pushing = satd_c && (((raw_ff > drive_c) && err_pos) ||
                               ((raw_ff < drive_c) && err_ff[W-1]));
   assign abs_a   = div_a_sel[W-1] ? (~div_a_sel + 1'b1) : div_a_sel;
   assign abs_b   = div_b_sel[W-1] ? (~div_b_sel + 1'b1) : div_b_sel;
   assign rem_sh  = {drem_ff, dq_ff[NW-1]};
   assign rem_ge  = rem_sh >= {1'b0, dden_ff};
   assign rem_sub = rem_sh - {1'b0, dden_ff};
   assign q_big   = |dq_ff[NW-1:W-1];
   assign integ_x = CW'(integ_ff);
   assign lim_x   = CW'({1'b0, limit_ff});
   assign nlim_x  = -lim_x;

   always_comb begin
      state_in = state_ff;       ret_in = ret_ff;
      cmd_in = cmd_ff;           setpoint_in = setpoint_ff;
      measured_in = measured_ff; step_time_in = step_time_ff;
      feedforward_in = feedforward_ff;
      drive_min_in = drive_min_ff; drive_max_in = drive_max_ff;
      amount_in = amount_ff;     err_in = err_ff;
      prop_in = prop_ff;         dy_in = dy_ff;
      corr_in = corr_ff;         deriv_in = deriv_ff;
      mul_a_in = mul_a_ff;       mul_b_in = mul_b_ff;
      prod_in = prod_ff;         dq_in = dq_ff;
      drem_in = drem_ff;         dden_in = dden_ff;
      dneg_in = dneg_ff;         dzero_in = dzero_ff;
      danum_in = danum_ff;       dcnt_in = dcnt_ff;
      divq_in = divq_ff;         drive_in = drive_ff;
      raw_in = raw_ff;           satd_in = satd_ff;
      integ_in = integ_ff;       filt_in = filt_ff;
      prev_in = prev_ff;         have_prev_in = have_prev_ff;
      mul_go = 1'b0;             div_go = 1'b0;
      mul_a_sel = '0;            mul_b_sel = '0;
      div_a_sel = '0;            div_b_sel = '0;
      ret_sel = ST_IDLE;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_command;
               setpoint_in = req_setpoint;
               measured_in = req_measured;
               step_time_in = req_step_time;
               feedforward_in = req_feedforward;
               drive_min_in = req_drive_min;
               drive_max_in = req_drive_max;
               amount_in = req_amount;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            drive_in = '0;
            raw_in = '0;
            satd_in = 1'b0;
            err_in = sat_s(ext(setpoint_ff) - ext(measured_ff));
            unique case (cmd_ff)
               CMD_UPDATE: begin
                  if (dt_pos) begin
                     mul_go = 1'b1; mul_a_sel = sw_ff; mul_b_sel = setpoint_ff;
                     ret_sel = ST_U_PE;
                  end else begin
                     raw_in = sat_s(ext(feedforward_ff) + ext(integ_ff));
                     state_in = ST_U_CLP;
                  end
               end
               CMD_RESET: begin
                  integ_in = amount_ff;
                  filt_in = '0;
                  have_prev_in = 1'b0;
                  state_in = ST_OUT;
               end
               CMD_BACK: begin
                  if (tt_pos && dt_pos) begin
                     div_go = 1'b1; div_a_sel = amount_ff; div_b_sel = tt_ff;
                     ret_sel = ST_C2_Q;
                  end else begin
                     state_in = ST_OUT;
                  end
               end
               CMD_ADD: begin
                  integ_in = sat_s(ext(integ_ff) + ext(amount_ff));
                  state_in = ST_I_CLAMP;
               end
               default: state_in = ST_OUT;
            endcase
         end
         ST_U_PE: begin
            mul_go = 1'b1; mul_a_sel = kp_ff;
            mul_b_sel = sat_s(ext(mulq) - ext(measured_ff));
            ret_sel = ST_U_P;
         end
         ST_U_P: begin
            prop_in = mulq;
            if ((kd_ff != '0) && have_prev_ff) begin
               div_go = 1'b1;
               div_a_sel = sat_s(ext(measured_ff) - ext(prev_ff));
               div_b_sel = step_time_ff;
               ret_sel = ST_U_DY;
            end else if (kd_ff != '0) begin
               state_in = ST_U_D;
            end else begin
               deriv_in = '0;
               state_in = ST_U_RAW;
            end
         end
         ST_U_DY: begin
            dy_in = divq_ff;
            div_go = 1'b1; div_a_sel = step_time_ff;
            div_b_sel = sat_s(ext(tf_pos) + ext(step_time_ff));
            ret_sel = ST_U_AL;
         end
         ST_U_AL: begin
            mul_go = 1'b1; mul_a_sel = divq_ff;
            mul_b_sel = sat_s(ext(dy_ff) - ext(filt_ff));
            ret_sel = ST_U_FL;
         end
         ST_U_FL: begin
            filt_in = sat_s(ext(filt_ff) + ext(mulq));
            state_in = ST_U_D;
         end
         ST_U_D: begin
            mul_go = 1'b1; mul_a_sel = kd_ff; mul_b_sel = filt_ff;
            ret_sel = ST_U_DN;
         end
         ST_U_DN: begin
            deriv_in = sat_s(-ext(mulq));
            state_in = ST_U_RAW;
         end
         ST_U_RAW: begin
            raw_in = sat_s(ext(feedforward_ff) + ext(prop_ff) + ext(integ_ff)
                           + ext(deriv_ff));
            prev_in = measured_ff;
            have_prev_in = 1'b1;
            state_in = ST_U_CLP;
         end
         ST_U_CLP: begin
            drive_in = drive_c;
            satd_in = satd_c;
            if (!dt_pos) begin
               state_in = ST_OUT;
            end else if (tt_pos) begin
               div_go = 1'b1;
               div_a_sel = sat_s(ext(drive_c) - ext(raw_ff));
               div_b_sel = tt_ff;
               ret_sel = ST_U_TC;
            end else if (pushing) begin
               state_in = ST_I_CLAMP;
            end else begin
               mul_go = 1'b1; mul_a_sel = ki_ff; mul_b_sel = err_ff;
               ret_sel = ST_U_KE;
            end
         end
         ST_U_TC: begin
            corr_in = divq_ff;
            mul_go = 1'b1; mul_a_sel = ki_ff; mul_b_sel = err_ff;
            ret_sel = ST_U_RT;
         end
         ST_U_RT: begin
            mul_go = 1'b1; mul_a_sel = sat_s(ext(mulq) + ext(corr_ff));
            mul_b_sel = step_time_ff;
            ret_sel = ST_U_IA;
         end
         ST_U_KE: begin
            mul_go = 1'b1; mul_a_sel = mulq; mul_b_sel = step_time_ff;
            ret_sel = ST_U_IA;
         end
         ST_C2_Q: begin
            mul_go = 1'b1; mul_a_sel = divq_ff; mul_b_sel = step_time_ff;
            ret_sel = ST_U_IA;
         end
         ST_U_IA: begin
            integ_in = sat_s(ext(integ_ff) + ext(mulq));
            state_in = ST_I_CLAMP;
         end
         ST_I_CLAMP: begin
            if (integ_x > lim_x) integ_in = lim_x[W-1:0];
            else if (integ_x < nlim_x) integ_in = nlim_x[W-1:0];
            state_in = ST_OUT;
         end
         ST_MUL: begin
            prod_in = mul_a_ff * mul_b_ff;
            state_in = ret_ff;
         end
         ST_DIV: begin
            drem_in = rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
            dq_in = {dq_ff[NW-2:0], rem_ge};
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == CNTW'(1)) state_in = ST_DIVFIN;
         end
         ST_DIVFIN: begin
            if (dzero_ff) divq_in = danum_ff ? VMIN : VMAX;
            else if (dneg_ff) divq_in = q_big ? VMIN : -dq_ff[W-1:0];
            else divq_in = q_big ? VMAX : dq_ff[W-1:0];
            state_in = ret_ff;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (mul_go) begin
         mul_a_in = mul_a_sel;
         mul_b_in = mul_b_sel;
         ret_in = ret_sel;
         state_in = ST_MUL;
      end
      if (div_go) begin
         dq_in = {abs_a, {F{1'b0}}};
         drem_in = '0;
         dden_in = abs_b;
         dneg_in = div_a_sel[W-1] ^ div_b_sel[W-1];
         dzero_in = div_b_sel == '0;
         danum_in = div_a_sel[W-1];
         dcnt_in = DIV_STEPS;
         ret_in = ret_sel;
         state_in = ST_DIV;
      end
   end

   always_comb begin
      kp_in = kp_ff; ki_in = ki_ff; kd_in = kd_ff; sw_in = sw_ff;
      tf_in = tf_ff; tt_in = tt_ff; limit_in = limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PROP_GAIN:    kp_in = csr_data;
            REG_INTEG_GAIN:   ki_in = csr_data;
            REG_DERIV_GAIN:   kd_in = csr_data;
            REG_SP_WEIGHT:    sw_in = csr_data;
            REG_DERIV_FILTER: tf_in = csr_data;
            REG_TRACK_TIME:   tt_in = csr_data;
            REG_INTEG_LIMIT:  limit_in = csr_data[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         integ_ff <= '0;
         filt_ff <= '0;
         prev_ff <= '0;
         have_prev_ff <= 1'b0;
         kp_ff <= '0;
         ki_ff <= '0;
         kd_ff <= '0;
         sw_ff <= W'(1) << F;
         tf_ff <= '0;
         tt_ff <= '0;
         limit_ff <= '1;
      end else begin
         state_ff <= state_in;
         integ_ff <= integ_in;
         filt_ff <= filt_in;
         prev_ff <= prev_in;
         have_prev_ff <= have_prev_in;
         kp_ff <= kp_in;
         ki_ff <= ki_in;
         kd_ff <= kd_in;
         sw_ff <= sw_in;
         tf_ff <= tf_in;
         tt_ff <= tt_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in;
      cmd_ff <= cmd_in;
      setpoint_ff <= setpoint_in;
      measured_ff <= measured_in;
      step_time_ff <= step_time_in;
      feedforward_ff <= feedforward_in;
      drive_min_ff <= drive_min_in;
      drive_max_ff <= drive_max_in;
      amount_ff <= amount_in;
      err_ff <= err_in;
      prop_ff <= prop_in;
      dy_ff <= dy_in;
      corr_ff <= corr_in;
      deriv_ff <= deriv_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      prod_ff <= prod_in;
      dq_ff <= dq_in;
      drem_ff <= drem_in;
      dden_ff <= dden_in;
      dneg_ff <= dneg_in;
      dzero_ff <= dzero_in;
      danum_ff <= danum_in;
      dcnt_ff <= dcnt_in;
      divq_ff <= divq_in;
      drive_ff <= drive_in;
      raw_ff <= raw_in;
      satd_ff <= satd_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_OUT;
   assign rsp_drive = drive_ff;
   assign rsp_raw_drive = raw_ff;
   assign rsp_saturated = satd_ff;
   assign rsp_integrator_value = integ_ff;
   assign csr_ready = 1'b1;

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("new word taken while result waits");

   a_sat_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_saturated == (rsp_drive != rsp_raw_drive)))
      else $error("saturated flag disagrees with drive");

   a_integ_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((cmd_ff == CMD_ADD) || ((cmd_ff == CMD_UPDATE) && dt_pos) ||
                     ((cmd_ff == CMD_BACK) && dt_pos && tt_pos)))
      |-> ((integ_x <= lim_x) && (integ_x >= nlim_x)))
      else $error("integrator outside its limit");

   a_accept_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("result shown without dispatch");
`endif

endmodule

// ===== test/tb_pid_controller_antiwindup_core.sv =====
// tb_pid_controller_antiwindup_core: self-checking bench for the pid core
// predicts each response word in fixed point and compares field by field;
// depends on pidaw_pkg and pid_controller_antiwindup_core
`timescale 1ns / 1ps

module tb_pid_controller_antiwindup_core;
   import pidaw_pkg::*;

   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;
   localparam int     ONE  = 65536;
   localparam int     EXP_DEPTH = 1024;

   typedef struct {
      longint drive;
      longint raw;
      bit     sat;
      longint integ;
   } pid_out_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [1:0] req_command;
   logic signed [31:0] req_setpoint, req_measured, req_step_time, req_feedforward;
   logic signed [31:0] req_drive_min, req_drive_max, req_amount;
   logic rsp_valid, rsp_stall, rsp_saturated;
   logic signed [31:0] rsp_drive, rsp_raw_drive, rsp_integrator_value;
   logic csr_valid, csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [31:0] csr_data;

   pid_controller_antiwindup_core dut (.*);

   // controller gains and limits as the core should hold them
   longint kp, ki, kd, sp_weight, filt_time, track_time, i_limit;
   // loop state
   longint integ, filt_deriv, prev_meas, last_raw;
   bit have_prev, sat_flag;

   // expected words, written by the sender and read by the checker
   pid_out_type exp_words[EXP_DEPTH];
   int exp_head = 0, exp_tail = 0;
   int errors = 0;
   int snd_idle_pct = 0, rcv_idle_pct = 0, hold_cycles = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic longint sat32(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      longint p;
      p = a * b;
      return sat32(p >>> 16);
   endfunction

   function automatic longint fx_div(longint a, longint b);
      if (b == 0) return (a < 0) ? QMIN : QMAX;
      return sat32((a <<< 16) / b);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic pid_out_type pid_step(logic [1:0] cmd, longint r, longint y, longint dt,
                                            longint ff, longint lo, longint hi, longint amt);
      pid_out_type o;
      longint e, p, d, dy, tf, alpha, corr, rate;
      bit pushing;
      o.drive = 0;
      o.raw = 0;
      o.sat = 0;
      case (cmd)
         CMD_UPDATE: begin
            if (hi < lo) hi = lo;
            if (dt <= 0) begin
               o.raw = sat32(ff + integ);
               o.drive = clip(o.raw, lo, hi);
               o.sat = o.drive != o.raw;
            end else begin
               e = sat32(r - y);
               p = fx_mul(kp, sat32(fx_mul(sp_weight, r) - y));
               d = 0;
               if (kd != 0) begin
                  if (have_prev) begin
                     dy = fx_div(sat32(y - prev_meas), dt);
                     tf = (filt_time < 0) ? 0 : filt_time;
                     alpha = fx_div(dt, sat32(tf + dt));
                     filt_deriv = sat32(filt_deriv + fx_mul(alpha, sat32(dy - filt_deriv)));
                  end
                  d = sat32(-fx_mul(kd, filt_deriv));
               end
               prev_meas = y;
               have_prev = 1;
               o.raw = sat32(ff + p + integ + d);
               o.drive = clip(o.raw, lo, hi);
               o.sat = o.drive != o.raw;
               last_raw = o.raw;
               sat_flag = o.sat;
               if (track_time > 0) begin
                  corr = fx_div(sat32(o.drive - o.raw), track_time);
                  rate = sat32(fx_mul(ki, e) + corr);
                  integ = sat32(integ + fx_mul(rate, dt));
               end else begin
                  pushing = o.sat && ((o.raw > o.drive && e > 0) ||
                                      (o.raw < o.drive && e < 0));
                  if (!pushing) integ = sat32(integ + fx_mul(fx_mul(ki, e), dt));
               end
               integ = clip(integ, -i_limit, i_limit);
            end
         end
         CMD_RESET: begin
            integ = amt;
            filt_deriv = 0;
            have_prev = 0;
            sat_flag = 0;
            last_raw = 0;
         end
         CMD_BACK: begin
            if (track_time > 0 && dt > 0) begin
               integ = sat32(integ + fx_mul(fx_div(amt, track_time), dt));
               integ = clip(integ, -i_limit, i_limit);
            end
         end
         default: begin
            integ = clip(sat32(integ + amt), -i_limit, i_limit);
         end
      endcase
      o.integ = integ;
      return o;
   endfunction

   // response checker
   always @(posedge clock) begin
      pid_out_type x;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (exp_tail == exp_head) begin
            $display("%0t: unexpected word drive=%0d", $time, rsp_drive);
            errors++;
         end else begin
            x = exp_words[exp_head % EXP_DEPTH];
            exp_head++;
            if (rsp_drive !== 32'(x.drive)) begin
               $display("%0t: drive exp %0d got %0d", $time, x.drive, rsp_drive);
               errors++;
            end
            if (rsp_raw_drive !== 32'(x.raw)) begin
               $display("%0t: raw_drive exp %0d got %0d", $time, x.raw, rsp_raw_drive);
               errors++;
            end
            if (rsp_saturated !== x.sat) begin
               $display("%0t: saturated exp %0d got %0d", $time, x.sat, rsp_saturated);
               errors++;
            end
            if (rsp_integrator_value !== 32'(x.integ)) begin
               $display("%0t: integrator exp %0d got %0d", $time, x.integ,
                        rsp_integrator_value);
               errors++;
            end
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < rcv_idle_pct);
      end
   end

   task automatic send_word(logic [1:0] cmd, int r, int y, int dt, int ff,
                            int lo, int hi, int amt);
      @(negedge clock);
      if ($urandom_range(99, 0) < snd_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_setpoint <= r;
      req_measured <= y;
      req_step_time <= dt;
      req_feedforward <= ff;
      req_drive_min <= lo;
      req_drive_max <= hi;
      req_amount <= amt;
      do @(posedge clock); while (req_stall);
      exp_words[exp_tail % EXP_DEPTH] = pid_step(cmd, r, y, dt, ff, lo, hi, amt);
      exp_tail++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (exp_tail != exp_head) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_PROP_GAIN:    kp = longint'(signed'(data));
         REG_INTEG_GAIN:   ki = longint'(signed'(data));
         REG_DERIV_GAIN:   kd = longint'(signed'(data));
         REG_SP_WEIGHT:    sp_weight = longint'(signed'(data));
         REG_DERIV_FILTER: filt_time = longint'(signed'(data));
         REG_TRACK_TIME:   track_time = longint'(signed'(data));
         REG_INTEG_LIMIT:  i_limit = longint'(data[30:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_all(int p, int i, int d, int b, int tf, int tt, int lim);
      write_reg(REG_PROP_GAIN, p);
      write_reg(REG_INTEG_GAIN, i);
      write_reg(REG_DERIV_GAIN, d);
      write_reg(REG_SP_WEIGHT, b);
      write_reg(REG_DERIV_FILTER, tf);
      write_reg(REG_TRACK_TIME, tt);
      write_reg(REG_INTEG_LIMIT, lim);
   endtask

   function automatic int any_val();
      case ($urandom_range(9, 0))
         0: return $urandom();
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         3: return 0;
         default: return $urandom_range(20 * ONE, 0) - 10 * ONE;
      endcase
   endfunction

   function automatic int step_val();
      case ($urandom_range(19, 0))
         0: return 0;
         1: return -$urandom_range(ONE, 1);
         2: return $urandom();
         default: return $urandom_range(ONE, 1);
      endcase
   endfunction

   task automatic random_word();
      logic [1:0] cmd;
      int k;
      k = $urandom_range(99, 0);
      cmd = (k < 70) ? CMD_UPDATE : (k < 80) ? CMD_RESET : (k < 90) ? CMD_BACK : CMD_ADD;
      send_word(cmd, any_val(), any_val(), step_val(), any_val(), any_val(), any_val(),
                any_val());
   endtask

   task automatic random_gains();
      set_all(any_val(), any_val(), ($urandom_range(3, 0) == 0) ? 0 : any_val(),
              ($urandom_range(1, 0)) ? ONE : any_val(), any_val(),
              ($urandom_range(1, 0)) ? $urandom_range(4 * ONE, 1) : any_val(),
              ($urandom_range(1, 0)) ? 32'h7fffffff : $urandom_range(50 * ONE, 0));
   endtask

   task automatic test_directed();
      set_all(2 * ONE, ONE, ONE / 2, ONE, ONE / 8, 0, 5 * ONE);
      send_word(CMD_UPDATE, ONE, 0, ONE / 10, 0, -ONE, ONE, 0);
      send_word(CMD_UPDATE, ONE, ONE / 4, ONE / 10, 0, -ONE, ONE, 0);
      send_word(CMD_UPDATE, 100 * ONE, 0, ONE, 0, -ONE, ONE, 0);
      send_word(CMD_UPDATE, -100 * ONE, 0, ONE, 0, -ONE, ONE, 0);
      send_word(CMD_UPDATE, ONE, 0, ONE, 0, ONE, -ONE, 0);
      send_word(CMD_UPDATE, ONE, 0, 0, ONE / 2, -ONE, ONE, 0);
      send_word(CMD_UPDATE, ONE, 0, -ONE, 9 * ONE, -ONE, ONE, 0);
      send_word(CMD_UPDATE, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                32'h80000000, 32'h7fffffff, 0);
      send_word(CMD_UPDATE, 32'h80000000, 32'h7fffffff, 1, 32'h80000000,
                32'h80000000, 32'h80000000, 0);
      send_word(CMD_RESET, 0, 0, 0, 0, 0, 0, 32'h7fffffff);
      send_word(CMD_ADD, 0, 0, 0, 0, 0, 0, 32'h7fffffff);
      send_word(CMD_ADD, 0, 0, 0, 0, 0, 0, 32'h80000000);
      send_word(CMD_BACK, 0, 0, ONE, 0, 0, 0, ONE);
      drain();
      set_all(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, -ONE, ONE / 2, 0);
      send_word(CMD_BACK, 0, 0, ONE, 0, 0, 0, ONE);
      send_word(CMD_BACK, 0, 0, 0, 0, 0, 0, ONE);
      send_word(CMD_UPDATE, ONE, -ONE, ONE, 0, -ONE, ONE, 0);
      send_word(CMD_UPDATE, -ONE, ONE, ONE / 3, 0, -ONE, ONE, 0);
      send_word(CMD_UPDATE, 5 * ONE, 0, ONE, 0, 0, 0, 0);
      send_word(CMD_ADD, 0, 0, 0, 0, 0, 0, ONE);
      drain();
      set_all(ONE, ONE, ONE, ONE, 0, 32'h80000000, 32'h7fffffff);
      send_word(CMD_UPDATE, 3 * ONE, 0, ONE, 0, -ONE, ONE, 0);
      send_word(CMD_UPDATE, -3 * ONE, 2 * ONE, ONE, 0, -ONE, ONE, 0);
      drain();
   endtask

   task automatic test_random(int n);
      repeat (4) begin
         random_gains();
         repeat (n / 4) random_word();
         drain();
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 400;
      repeat (20) random_word();
      // sender stops until every word has come back
      drain();
      repeat (20) random_word();
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_UPDATE;
      req_setpoint = 0;
      req_measured = 0;
      req_step_time = 0;
      req_feedforward = 0;
      req_drive_min = 0;
      req_drive_max = 0;
      req_amount = 0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_PROP_GAIN;
      csr_data = 0;
      kp = 0; ki = 0; kd = 0; sp_weight = ONE; filt_time = 0; track_time = 0;
      i_limit = QMAX;
      integ = 0; filt_deriv = 0; prev_meas = 0; last_raw = 0;
      have_prev = 0; sat_flag = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      snd_idle_pct = 15;
      rcv_idle_pct = 71;
      test_random(260);
      snd_idle_pct = 71;
      rcv_idle_pct = 15;
      test_random(260);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      test_random(240);
      test_backpressure();
      repeat (200) @(negedge clock);
      if (errors == 0 && exp_tail == exp_head) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== pid_controller_antiwindup_core.f =====
rtl/core/pidaw_pkg.sv
rtl/core/pid_controller_antiwindup_core.sv
test/tb_pid_controller_antiwindup_core.sv
